>>> hw/rtl/udmn_pkg.sv
package udmn_pkg;

    localparam int DATA_W  = 32;
    localparam int WIDE_W  = DATA_W + 1;
    localparam int SHIFT_W = 6;
    localparam int POS_W   = 5;
    localparam int ITER_W  = 6;

    localparam logic [POS_W-1:0]  LAST_DIV_STEP = POS_W'(DATA_W - 1);
    localparam logic [ITER_W-1:0] MAX_ITER      = ITER_W'(DATA_W);
    localparam logic [SHIFT_W-1:0] BASE_SHIFT   = SHIFT_W'(DATA_W);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_CHECK = 4'b0100,
        S_STEP  = 4'b1000
    } t_state;

endpackage

>>> hw/rtl/unsigned_div_magic_number.sv
// Channel   Direction  Transfer condition   Payload
// input     in         start && !busy       i_divisor
// result    out        o_done               o_multiplier, o_needs_fixup,
//                                           o_shift_amount, o_bad_divisor
//
// A valid divisor takes 32 restoring-division steps to reach 2^32 mod b, then
// alternating check/step cycles, one pair per search index i. All of it runs
// through one shared 33-bit subtractor. Divisor 0 or 1 gives its result the
// cycle after transfer. busy is high from transfer until the result cycle;
// o_done pulses one cycle. Synchronous active-low reset returns to idle; the
// receiver cannot stall.
module unsigned_div_magic_number import udmn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [DATA_W-1:0]  i_divisor,
    output logic               o_done,
    output logic [DATA_W-1:0]  o_multiplier,
    output logic               o_needs_fixup,
    output logic [SHIFT_W-1:0] o_shift_amount,
    output logic               o_bad_divisor
);

    t_state             r_state, n_state;
    logic [DATA_W-1:0]  r_div, n_div;
    logic [DATA_W-1:0]  r_rem, n_rem;
    logic [DATA_W-1:0]  r_quo, n_quo;
    logic [POS_W-1:0]   r_k, n_k;
    logic [ITER_W-1:0]  r_i, n_i;
    logic [WIDE_W-1:0]  r_pow, n_pow;
    logic [WIDE_W-1:0]  r_mask, n_mask;
    logic               r_done, n_done;
    logic [DATA_W-1:0]  r_mul, n_mul;
    logic               r_fix, n_fix;
    logic [SHIFT_W-1:0] r_sh, n_sh;
    logic               r_bad, n_bad;

    logic [WIDE_W-1:0]  w_a, w_b, w_diff;
    logic               w_borrow;
    logic [POS_W-1:0]   w_msb;
    logic               w_accept;
    logic [WIDE_W-1:0]  w_c;
    logic               w_fin;

    assign w_accept = start && !busy;

    always_comb begin
        if (r_state == S_CHECK) begin
            w_a = {1'b0, r_div};
            w_b = {1'b0, r_rem};
        end else begin
            w_a = {r_rem, 1'b0};
            w_b = {1'b0, r_div};
        end
    end

    udmn_sub u_sub (
        .i_a      (w_a),
        .i_b      (w_b),
        .o_diff   (w_diff),
        .o_borrow (w_borrow)
    );

    udmn_msb u_msb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_step  (r_state == S_DIV),
        .i_value (i_divisor),
        .o_msb   (w_msb)
    );

    // c = b - r; c <= 2^i when no bit above i-1 is set, or c is exactly 2^i
    assign w_c   = {1'b0, w_diff[DATA_W-1:0]};
    assign w_fin = (r_rem == '0) || ((w_c & ~r_mask) == '0) || (w_c == r_pow)
                   || (r_i == MAX_ITER);

    always_comb begin
        n_state = r_state;
        n_div   = r_div;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_k     = r_k;
        n_i     = r_i;
        n_pow   = r_pow;
        n_mask  = r_mask;
        n_done  = 1'b0;
        n_mul   = r_mul;
        n_fix   = r_fix;
        n_sh    = r_sh;
        n_bad   = r_bad;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_div  = i_divisor;
                    n_rem  = DATA_W'(1);
                    n_quo  = '0;
                    n_k    = '0;
                    n_i    = '0;
                    n_pow  = WIDE_W'(1);
                    n_mask = '0;
                    if (i_divisor < DATA_W'(2)) begin
                        n_mul  = '0;
                        n_fix  = 1'b0;
                        n_sh   = '0;
                        n_bad  = 1'b1;
                        n_done = 1'b1;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV, S_STEP: begin
                // r = 2r mod b, quotient gains one bit
                n_rem = w_borrow ? w_a[DATA_W-1:0] : w_diff[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], ~w_borrow};
                if (r_state == S_DIV) begin
                    n_k = r_k + POS_W'(1);
                    if (r_k == LAST_DIV_STEP) begin
                        n_state = S_CHECK;
                    end
                end else begin
                    n_i     = r_i + ITER_W'(1);
                    n_pow   = {r_pow[WIDE_W-2:0], 1'b0};
                    n_mask  = {r_mask[WIDE_W-2:0], 1'b1};
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_fin) begin
                    n_mul  = r_quo + DATA_W'(r_rem != '0);
                    n_bad  = 1'b0;
                    n_done = 1'b1;
                    if (r_i <= {1'b0, w_msb}) begin
                        n_fix = 1'b0;
                        n_sh  = BASE_SHIFT + SHIFT_W'(r_i);
                    end else begin
                        n_fix = 1'b1;
                        n_sh  = SHIFT_W'(w_msb);
                    end
                    n_state = S_IDLE;
                end else begin
                    n_state = S_STEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_k    <= n_k;
        r_i    <= n_i;
        r_pow  <= n_pow;
        r_mask <= n_mask;
        r_mul  <= n_mul;
        r_fix  <= n_fix;
        r_sh   <= n_sh;
        r_bad  <= n_bad;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_multiplier   = r_mul;
    assign o_needs_fixup  = r_fix;
    assign o_shift_amount = r_sh;
    assign o_bad_divisor  = r_bad;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_bad_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_divisor < DATA_W'(2)) |=> (o_done && o_bad_divisor))
        else $error("bad divisor not reported next cycle");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_divisor) |-> (o_multiplier == '0 && o_shift_amount == '0
                                       && !o_needs_fixup))
        else $error("bad divisor result carries nonzero fields");

    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_rem < r_div))
        else $error("remainder not reduced");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK || r_state == S_STEP) |-> (r_i <= MAX_ITER))
        else $error("search index overrun");

endmodule

>>> hw/rtl/udmn_sub.sv
module udmn_sub import udmn_pkg::*; (
    input  logic [WIDE_W-1:0] i_a,
    input  logic [WIDE_W-1:0] i_b,
    output logic [WIDE_W-1:0] o_diff,
    output logic              o_borrow
);

    logic [WIDE_W:0] w_full;

    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[WIDE_W-1:0];
    assign o_borrow = w_full[WIDE_W];

endmodule

>>> hw/rtl/udmn_msb.sv
module udmn_msb import udmn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_step,
    input  logic [DATA_W-1:0] i_value,
    output logic [POS_W-1:0]  o_msb
);

    logic [DATA_W-1:0] r_sh;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_msb;
    logic              r_found;

    // scans one bit per step from the top; first set bit gives floor(log2)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_load) begin
            r_found <= 1'b0;
        end else if (i_step && !r_found && r_sh[DATA_W-1]) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sh  <= i_value;
            r_pos <= POS_W'(DATA_W - 1);
        end else if (i_step) begin
            r_sh  <= {r_sh[DATA_W-2:0], 1'b0};
            r_pos <= r_pos - POS_W'(1);
            if (!r_found && r_sh[DATA_W-1]) begin
                r_msb <= r_pos;
            end
        end
    end

    assign o_msb = r_msb;

endmodule

>>> bench/tb_unsigned_div_magic_number.sv
module tb_unsigned_div_magic_number;
    import udmn_pkg::*;

    localparam int IDLE_LIMIT = 2000;  // cycles with no transfer on either side
    localparam int TAIL_WAIT  = 120;
    localparam int MAX_SHOWN  = 10;

    typedef struct {
        logic [DATA_W-1:0]  divisor;
        logic [DATA_W-1:0]  multiplier;
        logic               needs_fixup;
        logic [SHIFT_W-1:0] shift_amount;
        logic               bad_divisor;
    } magic_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [DATA_W-1:0]  i_divisor = '0;
    logic               busy;
    logic               o_done;
    logic [DATA_W-1:0]  o_multiplier;
    logic               o_needs_fixup;
    logic [SHIFT_W-1:0] o_shift_amount;
    logic               o_bad_divisor;

    magic_t pending_magic[$];
    int     error_cnt = 0;
    int     quiet_cycles = 0;

    unsigned_div_magic_number uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_divisor      (i_divisor),
        .o_done         (o_done),
        .o_multiplier   (o_multiplier),
        .o_needs_fixup  (o_needs_fixup),
        .o_shift_amount (o_shift_amount),
        .o_bad_divisor  (o_bad_divisor)
    );

    always #2 i_clk = ~i_clk;

    // Magic multiplier and shift for division by d, in 64-bit arithmetic.
    function automatic magic_t magic_for(input logic [DATA_W-1:0] d);
        magic_t      res;
        logic [63:0] b, r, c, pw, q, m;
        int          k;
        int          lg;
        res.divisor      = d;
        res.multiplier   = '0;
        res.needs_fixup  = 1'b0;
        res.shift_amount = '0;
        res.bad_divisor  = 1'b0;
        if (d < 2) begin
            res.bad_divisor = 1'b1;
            return res;
        end
        b = 64'(d);
        r = (64'd1 << 32) % b;
        c = '0;
        for (k = 0; k < 32; k++) begin
            if (r == 0) begin
                c = '0;
                break;
            end
            c = b - r;
            if (c <= (64'd1 << k))
                break;
            r = (r << 1) % b;
        end
        if (k == 32)
            c = (r == 0) ? 64'd0 : b - r;
        // 2^(32+k) wraps to zero at k = 32; the subtraction below stays exact
        pw = (k < 32) ? (64'd1 << (32 + k)) : 64'd0;
        q  = (pw - r) / b;
        m  = q + ((c != 0) ? 64'd1 : 64'd0);
        lg = 0;
        while ((b >> (lg + 1)) != 0)
            lg++;
        res.multiplier = m[DATA_W-1:0];
        if (k <= lg) begin
            res.needs_fixup  = 1'b0;
            res.shift_amount = SHIFT_W'(32 + k);
        end else begin
            res.needs_fixup  = 1'b1;
            res.shift_amount = SHIFT_W'(lg);
        end
        return res;
    endfunction

    // Input transfers queue a prediction, results are checked against the oldest one.
    always @(posedge i_clk) begin
        magic_t want;
        if (i_rst_n) begin
            if (start && !busy)
                pending_magic.push_back(magic_for(i_divisor));
            if (o_done) begin
                if (pending_magic.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= MAX_SHOWN)
                        $display("unexpected result: mult=%h fixup=%b shift=%0d bad=%b",
                                 o_multiplier, o_needs_fixup, o_shift_amount,
                                 o_bad_divisor);
                end else begin
                    want = pending_magic.pop_front();
                    if (o_multiplier !== want.multiplier ||
                        o_needs_fixup !== want.needs_fixup ||
                        o_shift_amount !== want.shift_amount ||
                        o_bad_divisor !== want.bad_divisor) begin
                        error_cnt++;
                        if (error_cnt <= MAX_SHOWN) begin
                            $write("divisor %h: expected mult=%h fixup=%b shift=%0d bad=%b",
                                   want.divisor, want.multiplier, want.needs_fixup,
                                   want.shift_amount, want.bad_divisor);
                            $display(", got mult=%h fixup=%b shift=%0d bad=%b",
                                     o_multiplier, o_needs_fixup, o_shift_amount,
                                     o_bad_divisor);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Leaves start high so a following item can go back to back.
    task automatic send_divisor(input logic [DATA_W-1:0] d);
        start     <= 1'b1;
        i_divisor <= d;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) begin
            i_divisor <= $urandom;
            @(posedge i_clk);
        end
    endtask

    // negedge first so the checker has queued the transfer of this edge
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_magic.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_divisor();
        logic [DATA_W-1:0] p;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return $urandom_range(0, 1000);
            3: begin
                p = 32'd1 << $urandom_range(0, 31);
                return p + DATA_W'($urandom_range(0, 2)) - 1;
            end
            4: return $urandom | 32'h8000_0000;
            default: return $urandom_range(2, 65535);
        endcase
    endfunction

    task automatic test_invalid_divisors();
        send_divisor(32'd0);
        send_divisor(32'd1);
        send_divisor(32'd0);
    endtask

    task automatic test_powers_of_two();
        send_divisor(32'd2);
        send_divisor(32'd4);
        send_divisor(32'h0001_0000);
        send_divisor(32'h8000_0000);
        send_divisor(32'd1 << $urandom_range(1, 31));
    endtask

    // Small divisors, fixup-form cases, values near 2^31, the all-ones/alternating patterns and 0x12345678.
    task automatic test_extremes();
        send_divisor(32'd3);
        send_divisor(32'd5);
        send_divisor(32'd6);
        send_divisor(32'd7);
        send_divisor(32'd10);
        send_divisor(32'd641);
        send_divisor(32'h7FFF_FFFF);
        send_divisor(32'h8000_0001);
        send_divisor(32'hFFFF_FFFE);
        send_divisor(32'hFFFF_FFFF);
        send_divisor(32'h5555_5555);
        send_divisor(32'hAAAA_AAAA);
        send_divisor(32'h1234_5678);
    endtask

    task automatic test_random(input int count, input int idle_pct);
        repeat (count) begin
            send_divisor(pick_divisor());
            if ($urandom_range(1, 100) <= idle_pct)
                idle_for($urandom_range(0, 1) ? $urandom_range(1, 4)
                                              : $urandom_range(5, 120));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_invalid_divisors();
        test_powers_of_two();
        test_extremes();
        wait_drained();
        test_random(550, 0);
        wait_drained();
        test_random(550, 57);
        wait_drained();
        test_random(500, 10);
        start <= 1'b0;
        while (pending_magic.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (error_cnt == 0 && pending_magic.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> unsigned_div_magic_number.f
hw/rtl/udmn_pkg.sv
hw/rtl/udmn_sub.sv
hw/rtl/udmn_msb.sv
hw/rtl/unsigned_div_magic_number.sv
bench/tb_unsigned_div_magic_number.sv
